// ----- rtl/deq_pkg.sv -----
package deq_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths on the ports
  localparam int VALUE_W  = 32;
  localparam int OCC_W    = 6;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Data returned by a pop that finds the queue empty
  localparam logic [VALUE_W-1:0] EMPTY_DATA = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue on a single-port circular RAM.
// A result is offered in the cycle after its input beat is accepted.
// Throughput: one operation per cycle unless stalled; each takes at most one
// RAM access (write for push, read for pop, none for dropped push/failed pop).
// Reset (rst_n low, synchronous): head index, item count and output valid
// clear; RAM contents are left as they are and need no clearing pass.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_data,
  output logic [STATUS_W-1:0]        out_status,
  output logic [OCC_W-1:0]           out_occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

  // Queue pointers
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Output stage
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [OCC_W-1:0]    occ_r;
  logic                from_ram_r;
  logic [VALUE_W-1:0]  fix_data_r;

  // Per-beat decode
  action_t             act;
  logic                accept;
  logic                full, empty;
  logic [IDX_W-1:0]    head_dec, head_inc;
  logic [SUM_W-1:0]    sum_tail, sum_back;
  logic [IDX_W-1:0]    tail_slot, back_slot;
  status_t             status_c;
  logic                from_ram_c;
  logic [VALUE_W-1:0]  fix_data_c;

  // RAM port
  logic                  ram_en, ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic signed [63:0]    val_ext, rd_ext;

  assign act      = action_t'(in_action);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  // Circular index arithmetic; sums stay below twice the depth
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
  assign sum_tail  = SUM_W'(head_r) + SUM_W'(count_r);
  assign sum_back  = sum_tail - SUM_W'(1);
  assign tail_slot = IDX_W'((sum_tail >= DEPTH_S) ? sum_tail - DEPTH_S : sum_tail);
  assign back_slot = IDX_W'((sum_back >= DEPTH_S) ? sum_back - DEPTH_S : sum_back);

  // Store items at DATA_WIDTH; widen popped items back to the port width
  assign val_ext   = 64'(in_value);
  assign ram_wdata = val_ext[DATA_WIDTH-1:0];
  assign rd_ext    = 64'(signed'(ram_rdata));

  // Operation decode: pointer update and the one RAM access
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_c   = ST_DONE;
    from_ram_c = 1'b0;
    fix_data_c = '0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = head_r;
    case (act)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + CNT_W'(1);
          ram_en    = accept;
          ram_we    = 1'b1;
          ram_addr  = head_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          ram_en    = accept;
          ram_we    = 1'b1;
          ram_addr  = tail_slot;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_c   = ST_EMPTY;
          fix_data_c = EMPTY_DATA;
        end else begin
          head_nxt   = head_inc;
          count_nxt  = count_r - CNT_W'(1);
          from_ram_c = 1'b1;
          ram_en     = accept;
          ram_addr   = head_r;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_c   = ST_EMPTY;
          fix_data_c = EMPTY_DATA;
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          from_ram_c = 1'b1;
          ram_en     = accept;
          ram_addr   = back_slot;
        end
      end
      default: begin
        status_c = ST_DONE;
      end
    endcase
  end

  // Item store. A write lands before any later read of the same slot can
  // issue, so no forwarding is needed.
  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; popped data comes straight from the RAM read register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_c;
      occ_r      <= OCC_W'(count_nxt);
      from_ram_r <= from_ram_c;
      fix_data_r <= fix_data_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;
  assign out_data      = from_ram_r ? rd_ext[VALUE_W-1:0] : fix_data_r;

endmodule

// ----- rtl/deq_ram.sv -----
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; read data holds while idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/deq_checker.sv -----
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [VALUE_W-1:0]  out_data,
  input logic [STATUS_W-1:0]        out_status,
  input logic [OCC_W-1:0]           out_occupancy
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
                                $stable(out_status) && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // Every accepted input beat produces a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted input beat");

  // A failed pop reports -1 and an empty queue
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_data == EMPTY_DATA &&
                                           out_occupancy == '0)
    else $error("empty pop result inconsistent");

  // A dropped push reports zero data and a full queue
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_data == '0 &&
                                          out_occupancy == FULL_OCC)
    else $error("full push result inconsistent");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
